@@ hw/rtl/ctc_pkg.sv @@
`default_nettype none

package ctc_pkg;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam int unsigned NS_DIGITS  = 9;
  localparam int unsigned DIV_STAGES = 64;

  // register indexes (paddr[3])
  localparam logic REG_RES    = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef struct packed {
    logic        func;
    logic [63:0] value_in;
  } item_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic        ok;
  } result_t;

  typedef enum logic [1:0] {
    RS_SMALL,
    RS_MID,
    RS_BIG,
    RS_BIN
  } res_e;

  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_ZERO
  } op_e;

  typedef struct packed {
    logic        func;
    op_e         op;
    logic        shr;
    logic [6:0]  e;
    logic        fail;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] d;
  } pipe_t;

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] r;
    case (n)
      5'd0:  r = 64'd1;
      5'd1:  r = 64'd10;
      5'd2:  r = 64'd100;
      5'd3:  r = 64'd1000;
      5'd4:  r = 64'd10000;
      5'd5:  r = 64'd100000;
      5'd6:  r = 64'd1000000;
      5'd7:  r = 64'd10000000;
      5'd8:  r = 64'd100000000;
      5'd9:  r = 64'd1000000000;
      5'd10: r = 64'd10000000000;
      5'd11: r = 64'd100000000000;
      5'd12: r = 64'd1000000000000;
      5'd13: r = 64'd10000000000000;
      5'd14: r = 64'd100000000000000;
      5'd15: r = 64'd1000000000000000;
      5'd16: r = 64'd10000000000000000;
      5'd17: r = 64'd100000000000000000;
      5'd18: r = 64'd1000000000000000000;
      5'd19: r = 64'd10000000000000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/capture_timestamp_convert.sv @@
`default_nettype none
// Capture timestamp converter.
// Input channel (in_valid_i / in_stall_o / in_item_i): one beat per timestamp,
// func 0 decodes a raw tick count to signed nanoseconds, func 1 encodes
// nanoseconds to ticks. Output channel (out_valid_o / out_stall_i /
// out_result_o): one beat per input beat, in order, with value_out and ok.
// Config over APB: resolution code at 0x0, offset in seconds at 0x8 (64 bit).
// Write config only while the pipe is empty.
// Throughput: one beat per cycle while no output beat is stalled. The input
// accept edge loads the first of six prep/multiply stages, then come a 64-stage
// restoring divider (one quotient bit a stage), a base stage and the output add
// stage, whose register drives out_result_o.
// A stall of a valid output beat freezes the whole pipe; a one-beat skid at the
// input takes the beat offered in that cycle, after which in_stall_o is high.
// Reset empties the pipe and the skid and sets code 6, offset 0. The offset
// product reaches the pipe through the partial-product registers and off_ns_q.
module capture_timestamp_convert (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ctc_pkg::item_t   in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ctc_pkg::result_t      out_result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  // config
  logic [7:0]  res_code_q;
  logic [63:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_code_q <= 8'd6;
      offset_q   <= 64'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3])
        ctc_pkg::REG_RES:    res_code_q <= pwdata[7:0];
        ctc_pkg::REG_OFFSET: offset_q   <= pwdata;
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == ctc_pkg::REG_OFFSET) ? offset_q : {56'd0, res_code_q};

  // offset * 1e9, 96-bit two's complement
  logic [61:0] off_lo_pp_d, off_lo_pp_q;
  logic [62:0] off_hi_pp_d, off_hi_pp_q;
  logic [95:0] off_hi_ext, off_ns_d, off_ns_q;

  assign off_lo_pp_d = 62'(offset_q[31:0]) * 62'(ctc_pkg::NS_PER_SEC[29:0]);
  assign off_hi_pp_d = 63'($signed(offset_q[63:32]))
                     * 63'($signed({1'b0, ctc_pkg::NS_PER_SEC[29:0]}));
  assign off_hi_ext  = {{33{off_hi_pp_q[62]}}, off_hi_pp_q};
  assign off_ns_d    = {off_hi_ext[63:0], 32'd0} + {34'd0, off_lo_pp_q};

  always_ff @(posedge clk_i) begin
    off_lo_pp_q <= off_lo_pp_d;
    off_hi_pp_q <= off_hi_pp_d;
    off_ns_q    <= off_ns_d;
  end

  // handshake
  logic            en, in_acc, skid_valid_q, out_valid_q;
  ctc_pkg::item_t  skid_q, s1_d;
  logic            s1_vld_d;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign s1_vld_d   = skid_valid_q || in_acc;
  assign s1_d       = skid_valid_q ? skid_q : in_item_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_acc) begin
      skid_q <= in_item_i;
    end
  end

  // stage registers
  logic                 s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q;
  logic                 f_vld_q;
  logic [ctc_pkg::DIV_STAGES-1:0] dvv_q;
  ctc_pkg::item_t       s1_q;

  logic                 s2_func_q;
  logic [63:0]          s2_v_q, s2_p_q;
  logic [6:0]           s2_e_q;
  ctc_pkg::res_e        s2_cls_q;

  logic                 s3_func_q;
  logic [63:0]          s3_v_q, s3_p_q;
  logic [6:0]           s3_e_q;
  ctc_pkg::res_e        s3_cls_q;
  logic [95:0]          s3_in_q;

  ctc_pkg::pipe_t       s4_d, s4_q, s5_d, s5_q, s6_d, s6_q;
  logic [63:0]          pp00_q, pp01_q, pp10_q, pp11_q;
  ctc_pkg::pipe_t       dv_src [ctc_pkg::DIV_STAGES];
  ctc_pkg::pipe_t       dv_d   [ctc_pkg::DIV_STAGES];
  ctc_pkg::pipe_t       dv_q   [ctc_pkg::DIV_STAGES];

  logic                 f_func_q, f_fail_q, f_fail_d;
  logic [95:0]          f_base_q, f_base_d;
  ctc_pkg::result_t     res_d, out_q;

  // stage 2: unit class and power of ten
  logic [6:0]    s2_e_d;
  ctc_pkg::res_e s2_cls_d;
  logic [63:0]   s2_p_d;

  always_comb begin
    s2_e_d = res_code_q[6:0];
    if (res_code_q[7]) begin
      s2_cls_d = ctc_pkg::RS_BIN;
      s2_p_d   = ctc_pkg::NS_PER_SEC;
    end else if (s2_e_d <= 7'(ctc_pkg::NS_DIGITS)) begin
      s2_cls_d = ctc_pkg::RS_SMALL;
      s2_p_d   = ctc_pkg::pow10(5'(4'(ctc_pkg::NS_DIGITS) - s2_e_d[3:0]));
    end else if (s2_e_d <= 7'd28) begin
      s2_cls_d = ctc_pkg::RS_MID;
      s2_p_d   = ctc_pkg::pow10(5'(s2_e_d - 7'(ctc_pkg::NS_DIGITS)));
    end else begin
      s2_cls_d = ctc_pkg::RS_BIG;
      s2_p_d   = 64'd0;
    end
  end

  // stage 4: operand select
  logic         in_zero, in_neg, bin_over;
  logic [223:0] bin_sh;

  always_comb begin
    in_zero  = (s3_in_q == 96'd0);
    in_neg   = s3_in_q[95];
    bin_sh   = {128'd0, s3_in_q} << s3_e_q;
    bin_over = |bin_sh[223:94];
    s4_d      = '0;
    s4_d.func = s3_func_q;
    s4_d.e    = s3_e_q;
    s4_d.op   = ctc_pkg::OP_ZERO;
    if (!s3_func_q) begin
      case (s3_cls_q)
        ctc_pkg::RS_SMALL: begin
          s4_d.op = ctc_pkg::OP_MUL;
          s4_d.lo = s3_v_q;
          s4_d.d  = s3_p_q;
        end
        ctc_pkg::RS_MID: begin
          s4_d.op = ctc_pkg::OP_DIV;
          s4_d.lo = s3_v_q;
          s4_d.d  = s3_p_q;
        end
        ctc_pkg::RS_BIN: begin
          s4_d.op  = ctc_pkg::OP_MUL;
          s4_d.lo  = s3_v_q;
          s4_d.d   = s3_p_q;
          s4_d.shr = 1'b1;
        end
        default: ;
      endcase
    end else begin
      case (s3_cls_q)
        ctc_pkg::RS_SMALL: begin
          s4_d.op   = ctc_pkg::OP_DIV;
          s4_d.hi   = {32'd0, s3_in_q[95:64]};
          s4_d.lo   = s3_in_q[63:0];
          s4_d.d    = s3_p_q;
          s4_d.fail = in_neg;
        end
        ctc_pkg::RS_MID: begin
          s4_d.op   = ctc_pkg::OP_MUL;
          s4_d.lo   = s3_in_q[63:0];
          s4_d.d    = s3_p_q;
          s4_d.fail = in_neg || (|s3_in_q[95:64]);
        end
        ctc_pkg::RS_BIN: begin
          if (!in_zero) begin
            s4_d.op   = ctc_pkg::OP_DIV;
            s4_d.hi   = {34'd0, bin_sh[93:64]};
            s4_d.lo   = bin_sh[63:0];
            s4_d.d    = s3_p_q;
            s4_d.fail = in_neg || bin_over;
          end
        end
        default: s4_d.fail = !in_zero;
      endcase
    end
  end

  // stage 5: partial products, quotient range check
  always_comb begin
    s5_d = s4_q;
    if (s4_q.op == ctc_pkg::OP_DIV && s4_q.hi >= s4_q.d) begin
      s5_d.fail = 1'b1;
    end
  end

  // stage 6: product sum
  logic [127:0] prod;

  always_comb begin
    prod = {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0} + {32'd0, pp10_q, 32'd0}
         + {pp11_q, 64'd0};
    s6_d = s5_q;
    if (s5_q.op == ctc_pkg::OP_MUL) begin
      s6_d.hi = prod[127:64];
      s6_d.lo = prod[63:0];
    end
  end

  // divider: one quotient bit a stage, remainder in hi, quotient shifts into lo
  logic [64:0] dv_t  [ctc_pkg::DIV_STAGES];
  logic        dv_ge [ctc_pkg::DIV_STAGES];
  logic [64:0] dv_r  [ctc_pkg::DIV_STAGES];

  always_comb begin
    for (int i = 0; i < ctc_pkg::DIV_STAGES; i++) begin
      dv_src[i] = (i == 0) ? s6_q : dv_q[(i == 0) ? 0 : i - 1];
      dv_t[i]   = {dv_src[i].hi, dv_src[i].lo[63]};
      dv_ge[i]  = dv_t[i] >= {1'b0, dv_src[i].d};
      dv_r[i]   = dv_t[i] - {1'b0, dv_src[i].d};
      dv_d[i]   = dv_src[i];
      if (dv_src[i].op == ctc_pkg::OP_DIV) begin
        dv_d[i].hi = dv_ge[i] ? dv_r[i][63:0] : dv_t[i][63:0];
        dv_d[i].lo = {dv_src[i].lo[62:0], dv_ge[i]};
      end
    end
  end

  // stage 7: base value
  ctc_pkg::pipe_t z;
  logic [127:0]   z_full, z_base;

  always_comb begin
    z      = dv_q[ctc_pkg::DIV_STAGES-1];
    z_full = {z.hi, z.lo};
    case (z.op)
      ctc_pkg::OP_MUL: z_base = z.shr ? (z_full >> z.e) : z_full;
      ctc_pkg::OP_DIV: z_base = {64'd0, z.lo};
      default:         z_base = 128'd0;
    endcase
    f_fail_d = z.fail;
    if (z.func) begin
      f_base_d = {32'd0, z_base[63:0]};
      if (z.op == ctc_pkg::OP_MUL && z.hi != 64'd0) begin
        f_fail_d = 1'b1;
      end
    end else begin
      f_base_d = z_base[95:0];
    end
  end

  // output: offset add and range check for func 0; func 1 passes the base through
  logic [97:0] sum;
  logic        ok;

  always_comb begin
    sum = {2'b00, f_base_q} + {{2{off_ns_q[95]}}, off_ns_q};
    if (f_func_q) begin
      ok = !f_fail_q;
    end else begin
      ok = !f_fail_q && ((&sum[97:63]) || !(|sum[97:63]));
    end
    res_d.ok        = ok;
    res_d.value_out = !ok ? 64'd0 : (f_func_q ? f_base_q[63:0] : sum[63:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      dvv_q       <= '0;
      f_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      s6_vld_q    <= s5_vld_q;
      dvv_q       <= {dvv_q[ctc_pkg::DIV_STAGES-2:0], s6_vld_q};
      f_vld_q     <= dvv_q[ctc_pkg::DIV_STAGES-1];
      out_valid_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      s2_func_q <= s1_q.func;
      s2_v_q    <= s1_q.value_in;
      s2_e_q    <= s2_e_d;
      s2_cls_q  <= s2_cls_d;
      s2_p_q    <= s2_p_d;
      s3_func_q <= s2_func_q;
      s3_v_q    <= s2_v_q;
      s3_e_q    <= s2_e_q;
      s3_cls_q  <= s2_cls_q;
      s3_p_q    <= s2_p_q;
      s3_in_q   <= {{32{s2_v_q[63]}}, s2_v_q} - off_ns_q;
      s4_q      <= s4_d;
      s5_q      <= s5_d;
      pp00_q    <= 64'(s4_q.lo[31:0])  * 64'(s4_q.d[31:0]);
      pp01_q    <= 64'(s4_q.lo[31:0])  * 64'(s4_q.d[63:32]);
      pp10_q    <= 64'(s4_q.lo[63:32]) * 64'(s4_q.d[31:0]);
      pp11_q    <= 64'(s4_q.lo[63:32]) * 64'(s4_q.d[63:32]);
      s6_q      <= s6_d;
      for (int i = 0; i < ctc_pkg::DIV_STAGES; i++) begin
        dv_q[i] <= dv_d[i];
      end
      f_func_q  <= z.func;
      f_fail_q  <= f_fail_d;
      f_base_q  <= f_base_d;
      out_q     <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/ctc_checker.sv @@
`default_nettype none

module ctc_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire ctc_pkg::result_t out_result_o
);

  // failed result carries zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_result_o.ok) |-> (out_result_o.value_out == 64'd0))
    else $error("failed result with nonzero value");

  // skid only fills from an offered beat
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stall without offered beat");

  // skid drains whenever output moves
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled while output free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_result_o)))
    else $error("stalled output beat changed");

endmodule

bind capture_timestamp_convert ctc_checker u_ctc_checker (.*);

`default_nettype wire
